// ----- rtl/mava_pkg.sv -----
// ----------------------------------------------------------------------------
// mava_pkg - mesh area and volume accumulator package
// Widths, micro-op table and shared types for the triangle accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mava_pkg;

	localparam int COORD_BITS = 16;
	localparam int NORM_BITS  = 16;
	localparam int EDGE_W     = COORD_BITS + 1;
	localparam int MUL_W      = 2 * EDGE_W + 1;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int ROOT_W     = ACC_W / 2;
	localparam int D_W        = 3 * COORD_BITS + 3;
	localparam int AREA_W     = 63;
	localparam int VOL_W      = 64;
	localparam int QE_W       = (D_W > VOL_W) ? D_W : VOL_W;
	localparam int DIVISOR    = 6;
	localparam int NUM_UOPS   = 21;
	localparam int UOP_W      = $clog2(NUM_UOPS + 1);

	// Divide by six one limb at a time: a three-bit remainder above a 16-bit
	// limb stays below 2^19, where the rounded-up reciprocal is exact
	localparam int DIV_LIMB_W  = 16;
	localparam int DIV_LIMBS   = (D_W + DIV_LIMB_W - 1) / DIV_LIMB_W;
	localparam int DIV_SHIFT   = 22;
	localparam int DIV_RECIP_W = 20;
	localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;

	typedef enum logic [4:0] {
		SRC_AX, SRC_AY, SRC_AZ,
		SRC_BX, SRC_BY, SRC_BZ,
		SRC_CX, SRC_CY, SRC_CZ,
		SRC_NX, SRC_NY, SRC_NZ,
		SRC_X1, SRC_Y1, SRC_Z1,
		SRC_X2, SRC_Y2, SRC_Z2,
		SRC_K0, SRC_K1, SRC_K2,
		SRC_QX, SRC_QY, SRC_QZ
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_K0, DST_K1, DST_K2,
		DST_QX, DST_QY, DST_QZ, DST_S, DST_D, DST_DOT
	} dst_t;

	typedef struct packed {
		src_t a;
		src_t b;
		logic first;
		logic sub;
		dst_t dst;
	} uop_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic sub;
		dst_t dst;
	} mac_ctl_t;

	typedef struct packed {
		logic                     en;
		dst_t                     dst;
		logic signed [ACC_W-1:0]  value;
	} mac_wr_t;

	// Operand order keeps each stored result written back before its first use
	function automatic uop_t uop_at(logic [UOP_W-1:0] idx);
		uop_t u;
		u = '{a: SRC_AX, b: SRC_AX, first: 1'b1, sub: 1'b0, dst: DST_NONE};
		unique case (int'(idx))
			0: u = '{SRC_Y1, SRC_Z2, 1'b1, 1'b0, DST_NONE};
			1: u = '{SRC_Y2, SRC_Z1, 1'b0, 1'b1, DST_K0};
			2: u = '{SRC_X1, SRC_Z2, 1'b1, 1'b0, DST_NONE};
			3: u = '{SRC_X2, SRC_Z1, 1'b0, 1'b1, DST_K1};
			4: u = '{SRC_X1, SRC_Y2, 1'b1, 1'b0, DST_NONE};
			5: u = '{SRC_X2, SRC_Y1, 1'b0, 1'b1, DST_K2};
			6: u = '{SRC_BY, SRC_CZ, 1'b1, 1'b0, DST_NONE};
			7: u = '{SRC_BZ, SRC_CY, 1'b0, 1'b1, DST_QX};
			8: u = '{SRC_K0, SRC_K0, 1'b1, 1'b0, DST_NONE};
			9: u = '{SRC_K1, SRC_K1, 1'b0, 1'b0, DST_NONE};
			10: u = '{SRC_K2, SRC_K2, 1'b0, 1'b0, DST_S};
			11: u = '{SRC_BZ, SRC_CX, 1'b1, 1'b0, DST_NONE};
			12: u = '{SRC_BX, SRC_CZ, 1'b0, 1'b1, DST_QY};
			13: u = '{SRC_BX, SRC_CY, 1'b1, 1'b0, DST_NONE};
			14: u = '{SRC_BY, SRC_CX, 1'b0, 1'b1, DST_QZ};
			15: u = '{SRC_AX, SRC_QX, 1'b1, 1'b0, DST_NONE};
			16: u = '{SRC_AY, SRC_QY, 1'b0, 1'b0, DST_NONE};
			17: u = '{SRC_AZ, SRC_QZ, 1'b0, 1'b0, DST_D};
			18: u = '{SRC_AX, SRC_NX, 1'b1, 1'b0, DST_NONE};
			19: u = '{SRC_AY, SRC_NY, 1'b0, 1'b0, DST_NONE};
			20: u = '{SRC_AZ, SRC_NZ, 1'b0, 1'b0, DST_DOT};
			default: u = '{SRC_AX, SRC_AX, 1'b1, 1'b0, DST_NONE};
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mava_mac.sv -----
// ----------------------------------------------------------------------------
// mava_mac - shared multiply-accumulate unit
// One signed multiplier with a registered product, then a signed accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mava_mac (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [mava_pkg::MUL_W-1:0]   op_a,
	input  wire logic signed [mava_pkg::MUL_W-1:0]   op_b,
	input  wire mava_pkg::mac_ctl_t                  ctl,
	output mava_pkg::mac_wr_t                        wr
);

	logic signed [mava_pkg::PROD_W-1:0] prod;
	logic signed [mava_pkg::PROD_W-1:0] prod_s1;
	mava_pkg::mac_ctl_t                 ctl_s1;
	logic signed [mava_pkg::ACC_W-1:0]  acc_q;
	logic signed [mava_pkg::ACC_W-1:0]  base;
	logic signed [mava_pkg::ACC_W-1:0]  addend;
	logic signed [mava_pkg::ACC_W-1:0]  sum;

	assign prod = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, first: 1'b0, sub: 1'b0, dst: mava_pkg::DST_NONE};
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (ctl_s1.valid) begin
			acc_q <= sum;
		end
	end

	assign addend = mava_pkg::ACC_W'(prod_s1);
	assign base   = ctl_s1.first ? '0 : acc_q;
	assign sum    = ctl_s1.sub ? (base - addend) : (base + addend);

	assign wr.en    = ctl_s1.valid && (ctl_s1.dst != mava_pkg::DST_NONE);
	assign wr.dst   = ctl_s1.dst;
	assign wr.value = sum;

endmodule

`default_nettype wire

// ----- rtl/mava_isqrt.sv -----
// ----------------------------------------------------------------------------
// mava_isqrt - iterative integer square root
// Restoring digit-by-digit root, two radicand bits per cycle, rounds down.
// ----------------------------------------------------------------------------
`default_nettype none

module mava_isqrt (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [mava_pkg::ACC_W-1:0]          radicand,
	output logic                                     busy,
	output logic [mava_pkg::ROOT_W-1:0]              root
);

	localparam int REM_W = mava_pkg::ROOT_W + 2;
	localparam int CNT_W = $clog2(mava_pkg::ROOT_W + 1);

	logic [mava_pkg::ACC_W-1:0] rad_q;
	logic [mava_pkg::ROOT_W-1:0] root_q;
	logic [REM_W-1:0]           rem_q;
	logic [REM_W-1:0]           cur;
	logic [REM_W-1:0]           trial;
	logic                       take;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;

	assign cur   = {rem_q[REM_W-3:0], rad_q[mava_pkg::ACC_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign take  = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(mava_pkg::ROOT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[mava_pkg::ACC_W-3:0], 2'b00};
			rem_q  <= take ? (cur - trial) : cur;
			root_q <= {root_q[mava_pkg::ROOT_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ----- rtl/mava_div6.sv -----
// ----------------------------------------------------------------------------
// mava_div6 - limb-wise divide by six
// Reciprocal multiplication on 16-bit limbs, most significant limb first;
// quotient limbs shift in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module mava_div6 (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [mava_pkg::D_W-1:0]            dividend,
	output logic                                     busy,
	output logic [mava_pkg::D_W-1:0]                 quot
);

	localparam int LW    = mava_pkg::DIV_LIMB_W;
	localparam int NL    = mava_pkg::DIV_LIMBS;
	localparam int PW    = LW * NL;
	localparam int CW    = LW + 3;
	localparam int RW    = mava_pkg::DIV_RECIP_W;
	localparam int CNT_W = $clog2(NL + 1);
	localparam logic [RW-1:0] RECIP = RW'(mava_pkg::DIV_RECIP);

	logic [PW-1:0]    num_q;
	logic [2:0]       rem_q;
	logic [CW-1:0]    cur;
	logic [CW+RW-1:0] prod;
	logic [LW-1:0]    digit;
	logic [CW-1:0]    back;
	logic [CW-1:0]    diff;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	assign cur   = {rem_q, num_q[PW-1 -: LW]};
	assign prod  = (CW+RW)'(cur) * (CW+RW)'(RECIP);
	assign digit = prod[mava_pkg::DIV_SHIFT +: LW];
	// six times the quotient digit
	assign back  = CW'({digit, 2'b00}) + CW'({digit, 1'b0});
	assign diff  = cur - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NL - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend limbs leave at the top while quotient limbs enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= PW'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[PW-LW-1:0], digit};
			rem_q <= diff[2:0];
		end
	end

	assign busy = busy_q;
	assign quot = num_q[mava_pkg::D_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/mesh_area_volume_accumulator.sv -----
// ----------------------------------------------------------------------------
// mesh_area_volume_accumulator - triangle area and signed volume totals
// Per triangle: cross product area via integer root, origin tetrahedron
// volume via determinant over six, both added into saturating totals.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              words
//  triangle     in   in_valid / in_ready    three vertices, facet normal
//  totals       out  out_valid / out_ready  area_total, volume_total
//
//  A triangle runs from accept to accept through 21 issue slots on the
//  shared multiplier and one drain slot, 36 root steps plus an exit check
//  (the 4-step divide by six runs beside the root), the total update, then
//  the idle state. The totals word is registered when the update commits.
//  in_ready is high only while idle; a result left untaken holds the next
//  triangle at its update step. Reset clears both totals.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_area_volume_accumulator (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_ready,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_a_x,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_a_y,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_a_z,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_b_x,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_b_y,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_b_z,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_c_x,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_c_y,
	input  wire logic signed [mava_pkg::COORD_BITS-1:0]   vertex_c_z,
	input  wire logic signed [mava_pkg::NORM_BITS-1:0]    normal_x,
	input  wire logic signed [mava_pkg::NORM_BITS-1:0]    normal_y,
	input  wire logic signed [mava_pkg::NORM_BITS-1:0]    normal_z,
	output logic                                          out_valid,
	input  wire logic                                     out_ready,
	output logic [mava_pkg::AREA_W-1:0]                   area_total,
	output logic signed [mava_pkg::VOL_W-1:0]             volume_total
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MAC    = 4'b0010,
		ST_ROOT   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	localparam int CB = mava_pkg::COORD_BITS;
	localparam int NB = mava_pkg::NORM_BITS;
	localparam int MW = mava_pkg::MUL_W;
	localparam int EW = mava_pkg::EDGE_W;
	localparam int AW = mava_pkg::ACC_W;

	state_t state_q;
	logic [mava_pkg::UOP_W-1:0] cnt_q;

	logic signed [CB-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic signed [NB-1:0] nx_q, ny_q, nz_q;
	logic signed [EW-1:0] x1, y1, z1, x2, y2, z2;
	logic signed [MW-1:0] k0_q, k1_q, k2_q, qx_q, qy_q, qz_q;
	logic signed [AW-1:0] s_q, d_q, d_abs;
	logic                 dot_neg_q;

	mava_pkg::uop_t    uop;
	mava_pkg::mac_ctl_t mac_ctl;
	mava_pkg::mac_wr_t  mac_wr;
	logic signed [MW-1:0] op_a, op_b;

	logic                               unit_start;
	logic                               sq_busy, dv_busy;
	logic [mava_pkg::ROOT_W-1:0]        sq_root;
	logic [mava_pkg::D_W-1:0]           dv_quot;
	logic [mava_pkg::QE_W-1:0]          q_ext;
	logic [mava_pkg::VOL_W-1:0]         vmag;

	logic [mava_pkg::AREA_W-1:0]        area_sum_q;
	logic signed [mava_pkg::VOL_W-1:0]  vol_sum_q;
	logic [mava_pkg::AREA_W:0]          area_wide;
	logic [mava_pkg::AREA_W-1:0]        area_next;
	logic signed [mava_pkg::VOL_W:0]    vol_add, vol_wide;
	logic signed [mava_pkg::VOL_W-1:0]  vol_next;
	logic                               out_valid_q;
	logic                               commit;

	assign x1 = EW'(ax_q) - EW'(bx_q);
	assign y1 = EW'(ay_q) - EW'(by_q);
	assign z1 = EW'(az_q) - EW'(bz_q);
	assign x2 = EW'(ax_q) - EW'(cx_q);
	assign y2 = EW'(ay_q) - EW'(cy_q);
	assign z2 = EW'(az_q) - EW'(cz_q);

	function automatic logic signed [MW-1:0] pick(mava_pkg::src_t s);
		logic signed [MW-1:0] v;
		v = '0;
		unique case (s)
			mava_pkg::SRC_AX: v = MW'(ax_q);
			mava_pkg::SRC_AY: v = MW'(ay_q);
			mava_pkg::SRC_AZ: v = MW'(az_q);
			mava_pkg::SRC_BX: v = MW'(bx_q);
			mava_pkg::SRC_BY: v = MW'(by_q);
			mava_pkg::SRC_BZ: v = MW'(bz_q);
			mava_pkg::SRC_CX: v = MW'(cx_q);
			mava_pkg::SRC_CY: v = MW'(cy_q);
			mava_pkg::SRC_CZ: v = MW'(cz_q);
			mava_pkg::SRC_NX: v = MW'(nx_q);
			mava_pkg::SRC_NY: v = MW'(ny_q);
			mava_pkg::SRC_NZ: v = MW'(nz_q);
			mava_pkg::SRC_X1: v = MW'(x1);
			mava_pkg::SRC_Y1: v = MW'(y1);
			mava_pkg::SRC_Z1: v = MW'(z1);
			mava_pkg::SRC_X2: v = MW'(x2);
			mava_pkg::SRC_Y2: v = MW'(y2);
			mava_pkg::SRC_Z2: v = MW'(z2);
			mava_pkg::SRC_K0: v = k0_q;
			mava_pkg::SRC_K1: v = k1_q;
			mava_pkg::SRC_K2: v = k2_q;
			mava_pkg::SRC_QX: v = qx_q;
			mava_pkg::SRC_QY: v = qy_q;
			mava_pkg::SRC_QZ: v = qz_q;
			default:          v = '0;
		endcase
		return v;
	endfunction

	assign uop  = mava_pkg::uop_at(cnt_q);
	always_comb begin
		op_a = pick(uop.a);
		op_b = pick(uop.b);
	end

	assign mac_ctl.valid = (state_q == ST_MAC) &&
		(cnt_q != mava_pkg::UOP_W'(mava_pkg::NUM_UOPS));
	assign mac_ctl.first = uop.first;
	assign mac_ctl.sub   = uop.sub;
	assign mac_ctl.dst   = uop.dst;

	mava_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl    (mac_ctl),
		.wr     (mac_wr)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ax_q <= vertex_a_x;
			ay_q <= vertex_a_y;
			az_q <= vertex_a_z;
			bx_q <= vertex_b_x;
			by_q <= vertex_b_y;
			bz_q <= vertex_b_z;
			cx_q <= vertex_c_x;
			cy_q <= vertex_c_y;
			cz_q <= vertex_c_z;
			nx_q <= normal_x;
			ny_q <= normal_y;
			nz_q <= normal_z;
		end
		if (mac_wr.en) begin
			unique case (mac_wr.dst)
				mava_pkg::DST_K0:  k0_q <= MW'(mac_wr.value);
				mava_pkg::DST_K1:  k1_q <= MW'(mac_wr.value);
				mava_pkg::DST_K2:  k2_q <= MW'(mac_wr.value);
				mava_pkg::DST_QX:  qx_q <= MW'(mac_wr.value);
				mava_pkg::DST_QY:  qy_q <= MW'(mac_wr.value);
				mava_pkg::DST_QZ:  qz_q <= MW'(mac_wr.value);
				mava_pkg::DST_S:   s_q <= mac_wr.value;
				mava_pkg::DST_D:   d_q <= mac_wr.value;
				mava_pkg::DST_DOT: dot_neg_q <= mac_wr.value[AW-1];
				default: begin
				end
			endcase
		end
	end

	// start both serial units once the last product has drained
	assign unit_start = (state_q == ST_MAC) &&
		(cnt_q == mava_pkg::UOP_W'(mava_pkg::NUM_UOPS));
	assign d_abs = d_q[AW-1] ? -d_q : d_q;

	mava_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (unit_start),
		.radicand (s_q),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	mava_div6 u_div6 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (unit_start),
		.dividend (d_abs[mava_pkg::D_W-1:0]),
		.busy     (dv_busy),
		.quot     (dv_quot)
	);

	// area: half the root, saturating add
	assign area_wide = {1'b0, area_sum_q} +
		(mava_pkg::AREA_W + 1)'(sq_root >> 1);
	assign area_next = area_wide[mava_pkg::AREA_W] ? '1 : area_wide[mava_pkg::AREA_W-1:0];

	// volume: clamp magnitude, apply sign of A.N, saturating add
	assign q_ext = mava_pkg::QE_W'(dv_quot);
	assign vmag  = (|q_ext[mava_pkg::QE_W-1:mava_pkg::VOL_W-1]) ?
		{1'b0, {(mava_pkg::VOL_W-1){1'b1}}} : q_ext[mava_pkg::VOL_W-1:0];
	assign vol_add  = dot_neg_q ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
	assign vol_wide = (mava_pkg::VOL_W + 1)'(vol_sum_q) + vol_add;
	always_comb begin
		if (vol_wide[mava_pkg::VOL_W] != vol_wide[mava_pkg::VOL_W-1]) begin
			vol_next = vol_wide[mava_pkg::VOL_W] ?
				{1'b1, {(mava_pkg::VOL_W-1){1'b0}}} : {1'b0, {(mava_pkg::VOL_W-1){1'b1}}};
		end else begin
			vol_next = vol_wide[mava_pkg::VOL_W-1:0];
		end
	end

	assign commit = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			area_sum_q  <= '0;
			vol_sum_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				area_sum_q  <= area_next;
				vol_sum_q   <= vol_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
					end
				end
				ST_MAC: begin
					if (unit_start) begin
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (!sq_busy && !dv_busy) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign area_total   = area_sum_q;
	assign volume_total = vol_sum_q;

`ifndef SYNTHESIS
	a_accept_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!sq_busy && !dv_busy))
		else $error("word accepted while serial units busy");

	a_area_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (area_sum_q >= $past(area_sum_q)))
		else $error("area total decreased");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (out_valid && state_q == ST_IDLE))
		else $error("committed word not presented");

	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> ($stable(area_sum_q) && $stable(vol_sum_q)))
		else $error("totals changed outside update");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_mesh_area_volume_accumulator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mesh_area_volume_accumulator - triangle area and volume totals bench
// Drives triangles through the valid/ready input, recomputes both saturating
// totals in an exact-integer predictor and compares every totals word, under
// phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mesh_area_volume_accumulator;

	localparam int CB = mava_pkg::COORD_BITS;
	localparam int NB = mava_pkg::NORM_BITS;
	localparam int AW = mava_pkg::AREA_W;
	localparam int VW = mava_pkg::VOL_W;
	localparam int N_RANDOM = 1300;
	localparam logic [63:0] AREA_MAX = 64'h7fff_ffff_ffff_ffff;

	typedef struct {
		logic signed [CB-1:0] v[9];
		logic signed [NB-1:0] n[3];
	} tri_t;

	typedef struct {
		logic [AW-1:0]        area;
		logic signed [VW-1:0] vol;
	} totals_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] vtx[9] = '{default: '0};
	logic signed [NB-1:0] nrm[3] = '{default: '0};
	logic out_valid;
	logic out_ready = 1'b0;
	logic [AW-1:0]        area_total;
	logic signed [VW-1:0] volume_total;

	tri_t    pending_tris[$];
	totals_t expected_totals[$];
	logic [AW-1:0]        area_acc = '0;
	logic signed [VW-1:0] vol_acc = '0;
	logic in_fire = 1'b0;
	int   n_driven = 0;
	int   n_errors = 0;
	int   idle_mode;

	always #10 clk = ~clk;

	mesh_area_volume_accumulator i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vertex_a_x(vtx[0]), .vertex_a_y(vtx[1]), .vertex_a_z(vtx[2]),
		.vertex_b_x(vtx[3]), .vertex_b_y(vtx[4]), .vertex_b_z(vtx[5]),
		.vertex_c_x(vtx[6]), .vertex_c_y(vtx[7]), .vertex_c_z(vtx[8]),
		.normal_x(nrm[0]), .normal_y(nrm[1]), .normal_z(nrm[2]),
		.out_valid(out_valid), .out_ready(out_ready),
		.area_total(area_total), .volume_total(volume_total)
	);

	function automatic longint absl(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// Fold one triangle into the running totals and return them
	function automatic totals_t accumulate_triangle(tri_t t);
		longint a[3], b[3], c[3], e1[3], e2[3], k[3], q[3];
		longint d, dot, vmag;
		logic [127:0] s, root, cand;
		logic [63:0] area, asum;
		logic signed [127:0] vsum;
		totals_t r;
		for (int i = 0; i < 3; i++) begin
			a[i] = t.v[i]; b[i] = t.v[3+i]; c[i] = t.v[6+i];
			e1[i] = a[i] - b[i]; e2[i] = a[i] - c[i];
		end
		k[0] = e1[1]*e2[2] - e2[1]*e1[2];
		k[1] = e1[0]*e2[2] - e2[0]*e1[2];
		k[2] = e1[0]*e2[1] - e2[0]*e1[1];
		s = 128'(absl(k[0])) * 128'(absl(k[0])) + 128'(absl(k[1])) * 128'(absl(k[1]))
			+ 128'(absl(k[2])) * 128'(absl(k[2]));
		root = '0;
		for (int bitn = 53; bitn >= 0; bitn--) begin
			cand = root | (128'd1 << bitn);
			if (cand * cand <= s) root = cand;
		end
		area = 64'(root >> 1);
		asum = {1'b0, area_acc} + area;
		area_acc = (asum > AREA_MAX || area > AREA_MAX) ? AREA_MAX[62:0] : asum[62:0];

		q[0] = b[1]*c[2] - b[2]*c[1];
		q[1] = b[2]*c[0] - b[0]*c[2];
		q[2] = b[0]*c[1] - b[1]*c[0];
		d = a[0]*q[0] + a[1]*q[1] + a[2]*q[2];
		dot = a[0]*longint'(t.n[0]) + a[1]*longint'(t.n[1]) + a[2]*longint'(t.n[2]);
		vmag = absl(d) / 6;
		vsum = (dot < 0) ? 128'(vol_acc) - 128'(vmag) : 128'(vol_acc) + 128'(vmag);
		// clamp to the 64-bit signed range
		if (vsum > 128'sh7fff_ffff_ffff_ffff) vol_acc = 64'sh7fff_ffff_ffff_ffff;
		else if (vsum < -128'sh8000_0000_0000_0000) vol_acc = 64'sh8000_0000_0000_0000;
		else vol_acc = vsum[63:0];
		r.area = area_acc;
		r.vol = vol_acc;
		return r;
	endfunction

	function automatic tri_t make_tri(int span);
		tri_t t;
		for (int i = 0; i < 9; i++)
			t.v[i] = (span == 0) ? CB'($urandom)
				: CB'($urandom_range(2*span) - span);
		for (int i = 0; i < 3; i++)
			t.n[i] = ($urandom_range(9) == 0) ? NB'($urandom)
				: NB'($urandom_range(32768) - 16384);
		return t;
	endfunction

	// Idle chance in percent for the current phase: none, sender, receiver, both
	function automatic bit idle_now(bit is_sender);
		case (idle_mode)
			1: return is_sender && ($urandom_range(99) < 45);
			2: return !is_sender && ($urandom_range(99) < 45);
			3: return $urandom_range(99) < 13;
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			tri_t t;
			for (int i = 0; i < 9; i++) t.v[i] = vtx[i];
			for (int i = 0; i < 3; i++) t.n[i] = nrm[i];
			expected_totals.insert(expected_totals.size(), accumulate_triangle(t));
		end
		if (out_valid && out_ready) begin
			if (expected_totals.size() == 0) begin
				$display("%t: unexpected word area=%0d volume=%0d", $realtime,
					area_total, volume_total);
				n_errors++;
			end else begin
				totals_t e;
				e = expected_totals.pop_front();
				if (area_total !== e.area) begin
					$display("%t: area_total expected %0d actual %0d", $realtime,
						e.area, area_total);
					n_errors++;
				end
				if (volume_total !== e.vol) begin
					$display("%t: volume_total expected %0d actual %0d", $realtime,
						e.vol, volume_total);
					n_errors++;
				end
			end
		end
	end

	// Driver: hold the word until taken, then advance or idle
	always @(negedge clk) begin
		idle_mode = (n_driven / 120) % 4;
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_tris.size() != 0 && !idle_now(1'b1)) begin
				tri_t t;
				t = pending_tris.pop_front();
				for (int i = 0; i < 9; i++) vtx[i] <= t.v[i];
				for (int i = 0; i < 3; i++) nrm[i] <= t.n[i];
				in_valid <= 1'b1;
				n_driven++;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && !idle_now(1'b0);
	end

	initial begin
		tri_t t;
		// Directed: extremes, degenerate, sign of the normal dot
		t = make_tri(0);
		for (int i = 0; i < 9; i++) t.v[i] = '0;
		for (int i = 0; i < 3; i++) t.n[i] = '0;
		pending_tris.insert(pending_tris.size(), t);
		for (int i = 0; i < 9; i++) t.v[i] = 16'sh7fff;
		pending_tris.insert(pending_tris.size(), t);
		for (int i = 0; i < 9; i++) t.v[i] = 16'sh8000;
		pending_tris.insert(pending_tris.size(), t);
		for (int p = 0; p < 8; p++) begin
			for (int i = 0; i < 9; i++)
				t.v[i] = ((p >> (i % 3)) & 1) ^ (i / 3 == 1) ? 16'sh7fff : 16'sh8000;
			t.v[3*(p%3) + (p%3)] = '0;
			t.n[0] = (p & 1) ? 16'sd16384 : -16'sd16384;
			t.n[1] = (p & 2) ? 16'sd16384 : -16'sd16384;
			t.n[2] = (p & 4) ? 16'sh7fff : 16'sh8000;
			pending_tris.insert(pending_tris.size(), t);
		end
		// collinear vertices
		t.v = '{16'sd100, 16'sd200, 16'sd300, 16'sd200, 16'sd400, 16'sd600,
			-16'sd100, -16'sd200, -16'sd300};
		pending_tris.insert(pending_tris.size(), t);
		// normal perpendicular to A gives a zero dot
		t.v = '{16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd512, 16'sd0, 16'sd0, 16'sd0, 16'sd768};
		t.n = '{16'sd0, 16'sd16384, -16'sd16384};
		pending_tris.insert(pending_tris.size(), t);
		t.n = '{-16'sd16384, 16'sd0, 16'sd0};
		pending_tris.insert(pending_tris.size(), t);
		t.n = '{16'sd16384, 16'sd0, 16'sd0};
		pending_tris.insert(pending_tris.size(), t);
		for (int i = 0; i < N_RANDOM; i++)
			pending_tris.insert(pending_tris.size(),
				make_tri(($urandom_range(3) == 0) ? 300 : 0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_tris.size() != 0) @(posedge clk);
		@(posedge clk);
		while (in_valid || expected_totals.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/mava_pkg.sv
rtl/mava_mac.sv
rtl/mava_isqrt.sv
rtl/mava_div6.sv
rtl/mesh_area_volume_accumulator.sv
tb/tb_mesh_area_volume_accumulator.sv
